FILE: hdl/ipss_pkg.sv
// shared types, constants and op codes for the image pair score select block
package ipss_pkg;

  // table sizes
  localparam int MAX_PAIRS  = 1024;
  localparam int PAIR_AW    = 10;
  localparam int MAX_IMAGES = 4096;
  localparam int IMG_AW     = 12;
  localparam int DEG_W      = 12;
  localparam logic [DEG_W-1:0] DEG_MAX = 12'hFFF;

  // fixed point
  localparam int LOG_FRAC_BITS = 12;
  localparam int LN_SHIFT      = 58 - LOG_FRAC_BITS;
  localparam int TI_SHIFT      = LOG_FRAC_BITS - 4;
  localparam logic [27:0] LN2_Q28 = 28'd186065280;
  localparam int PENALTY       = 5 * 4096;

  // op codes
  localparam logic [2:0] OP_CLEAR_PAIRS = 3'd0;
  localparam logic [2:0] OP_ADD_PAIR    = 3'd1;
  localparam logic [2:0] OP_REG_IMAGE   = 3'd2;
  localparam logic [2:0] OP_CLEAR_REG   = 3'd3;
  localparam logic [2:0] OP_QUERY       = 3'd4;
  localparam logic [2:0] OP_CHOOSE      = 3'd5;

  // result codes
  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_FULL    = 2'd1;
  localparam logic [1:0] RC_RANGE   = 2'd2;
  localparam logic [1:0] RC_NONE    = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_W_INLIERS = 2'd0;
  localparam logic [1:0] CFG_W_CONNECT = 2'd1;
  localparam logic [1:0] CFG_W_STABLE  = 2'd2;

  // one stored pair
  typedef struct packed {
    logic [IMG_AW-1:0] im1;
    logic [IMG_AW-1:0] im2;
    logic signed [20:0] inl;
    logic fok;
    logic tv;
    logic st;
    logic dg;
  } pair_rec_t;

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_ADD_WA, ST_ADD_WB, ST_C_RD, ST_PAIR_RD,
    ST_IMG_CHK, ST_SCORE, ST_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    SC_IDLE, SC_NORM, SC_SQ, SC_PLO, SC_PHI, SC_LN, SC_MUL, SC_SUM
  } sc_state_t;

endpackage

FILE: hdl/image_pair_score_select.sv
// top level: pair table, degree and registration memories, op sequencer
//
//  channel  | direction | fields
//  s_*      | in        | s_tuser: op; s_tdata: lead_image, second_image, inlier_count,
//           |           |   fund_ok, twoview_good, is_stable, degenerate, query_index
//  m_*      | out       | m_tuser: result_code; m_tdata: best_first, best_second,
//           |           |   best_index, score_value
//  cfg_*    | in        | cfg_index, cfg_data: weight_inliers, weight_connect, weight_stable
//
// add writes the pair and bumps both image degrees, register sets one map entry, and
// query runs the score unit (normalize steps, then 30 squarings). choose reads the pair
// table one entry at a time and runs the score unit only on pairs that it does not skip.
// clear pairs and clear registered each sweep their 4096-entry memory, one
// entry a cycle; after reset one sweep clears both, no request taken.
// a finished result waits in the output register while the next request is taken.
module image_pair_score_select (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // lead_image, second_image, inlier_count, fund_ok,
                                 // twoview_good, is_stable, degenerate, query_index, pad
  input  logic [2:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // best_first, best_second, best_index, score_value, pad
  output logic [1:0]  m_tuser,   // result_code
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IMG_AW  = ipss_pkg::IMG_AW;
  localparam int PAIR_AW = ipss_pkg::PAIR_AW;

  ipss_pkg::top_state_t state, state_next;

  // memories
  ipss_pkg::pair_rec_t pair_mem [ipss_pkg::MAX_PAIRS];
  logic [ipss_pkg::DEG_W-1:0] deg_mem [ipss_pkg::MAX_IMAGES];
  logic reg_mem [ipss_pkg::MAX_IMAGES];

  ipss_pkg::pair_rec_t pair_rd, in_rec, req_rec;
  logic [ipss_pkg::DEG_W-1:0] deg_a, deg_b, nb;
  logic reg_a, reg_b;

  logic pair_re, pair_we, img_re, deg_we, reg_we, reg_wdata;
  logic [PAIR_AW-1:0] pair_raddr;
  logic [IMG_AW-1:0] img_ra_a, img_ra_b, deg_waddr, reg_waddr;
  logic [ipss_pkg::DEG_W-1:0] deg_wdata, na;

  logic [2:0] req_op;
  logic [PAIR_AW-1:0] req_q;
  logic [PAIR_AW:0] pair_count, idx;
  logic [IMG_AW-1:0] sweep_addr;
  logic sweep_deg, sweep_reg, sweep_op;
  logic found;
  logic signed [31:0] best;
  logic signed [15:0] w_inl, w_con, w_stb;
  logic [1:0] res_code;
  logic [IMG_AW-1:0] res_bf, res_bs;
  logic [PAIR_AW-1:0] res_bi;
  logic signed [31:0] res_sc;

  logic s_acc, out_load, sc_start, sc_done, skip, full_tbl;
  logic signed [31:0] sc_val;
  logic [12:0] dsum;

  // input unpacking
  always_comb begin
    in_rec.im1 = s_tdata[11:0];
    in_rec.im2 = s_tdata[23:12];
    in_rec.inl = signed'(s_tdata[44:24]);
    in_rec.fok = s_tdata[45];
    in_rec.tv  = s_tdata[46];
    in_rec.st  = s_tdata[47];
    in_rec.dg  = s_tdata[48];
  end

  assign s_tready = (state == ipss_pkg::ST_IDLE);
  assign s_acc = s_tvalid && s_tready;
  assign out_load = (state == ipss_pkg::ST_DONE) && (!m_tvalid || m_tready);
  assign full_tbl = (pair_count == (PAIR_AW+1)'(ipss_pkg::MAX_PAIRS));
  assign skip = (req_op == ipss_pkg::OP_CHOOSE) &&
                (!pair_rd.fok || pair_rd.dg || reg_a || reg_b);
  assign dsum = {1'b0, deg_a} + {1'b0, deg_b};
  assign na = (deg_a == ipss_pkg::DEG_MAX) ? deg_a : deg_a + 12'd1;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipss_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    pair_re = 1'b0;
    pair_we = 1'b0;
    pair_raddr = idx[PAIR_AW-1:0];
    img_re = 1'b0;
    img_ra_a = pair_rd.im1;
    img_ra_b = pair_rd.im2;
    deg_we = 1'b0;
    deg_waddr = sweep_addr;
    deg_wdata = '0;
    reg_we = 1'b0;
    reg_waddr = sweep_addr;
    reg_wdata = 1'b0;
    sc_start = 1'b0;
    case (state)
      ipss_pkg::ST_SWEEP: begin
        deg_we = sweep_deg;
        reg_we = sweep_reg;
        if (sweep_addr == IMG_AW'(ipss_pkg::MAX_IMAGES - 1)) begin
          state_next = sweep_op ? ipss_pkg::ST_DONE : ipss_pkg::ST_IDLE;
        end
      end
      ipss_pkg::ST_IDLE: begin
        img_ra_a = in_rec.im1;
        img_ra_b = in_rec.im2;
        pair_raddr = s_tdata[58:49];
        if (s_acc) begin
          case (s_tuser)
            ipss_pkg::OP_CLEAR_PAIRS, ipss_pkg::OP_CLEAR_REG: begin
              state_next = ipss_pkg::ST_SWEEP;
            end
            ipss_pkg::OP_ADD_PAIR: begin
              if (full_tbl) begin
                state_next = ipss_pkg::ST_DONE;
              end else begin
                pair_we = 1'b1;
                img_re = 1'b1;
                state_next = ipss_pkg::ST_ADD_WA;
              end
            end
            ipss_pkg::OP_REG_IMAGE: begin
              reg_we = 1'b1;
              reg_waddr = in_rec.im1;
              reg_wdata = 1'b1;
              state_next = ipss_pkg::ST_DONE;
            end
            ipss_pkg::OP_QUERY: begin
              if ({1'b0, s_tdata[58:49]} >= pair_count) begin
                state_next = ipss_pkg::ST_DONE;
              end else begin
                pair_re = 1'b1;
                state_next = ipss_pkg::ST_PAIR_RD;
              end
            end
            ipss_pkg::OP_CHOOSE: state_next = ipss_pkg::ST_C_RD;
            default: state_next = ipss_pkg::ST_DONE;
          endcase
        end
      end
      ipss_pkg::ST_ADD_WA: begin
        deg_we = 1'b1;
        deg_waddr = req_rec.im1;
        deg_wdata = na;
        state_next = ipss_pkg::ST_ADD_WB;
      end
      ipss_pkg::ST_ADD_WB: begin
        deg_we = 1'b1;
        deg_waddr = req_rec.im2;
        deg_wdata = nb;
        state_next = ipss_pkg::ST_DONE;
      end
      ipss_pkg::ST_C_RD: begin
        if (idx == pair_count) begin
          state_next = ipss_pkg::ST_DONE;
        end else begin
          pair_re = 1'b1;
          state_next = ipss_pkg::ST_PAIR_RD;
        end
      end
      ipss_pkg::ST_PAIR_RD: begin
        img_re = 1'b1;
        state_next = ipss_pkg::ST_IMG_CHK;
      end
      ipss_pkg::ST_IMG_CHK: begin
        if (skip) begin
          state_next = ipss_pkg::ST_C_RD;
        end else begin
          sc_start = 1'b1;
          state_next = ipss_pkg::ST_SCORE;
        end
      end
      ipss_pkg::ST_SCORE: begin
        if (sc_done) begin
          state_next = (req_op == ipss_pkg::OP_CHOOSE) ? ipss_pkg::ST_C_RD
                                                       : ipss_pkg::ST_DONE;
        end
      end
      ipss_pkg::ST_DONE: if (out_load) state_next = ipss_pkg::ST_IDLE;
      default: state_next = ipss_pkg::ST_IDLE;
    endcase
  end

  // pair table
  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_count[PAIR_AW-1:0]] <= in_rec;
    end
    if (pair_re) begin
      pair_rd <= pair_mem[pair_raddr];
    end
  end

  // degree table, two read ports
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    if (img_re) begin
      deg_a <= deg_mem[img_ra_a];
      deg_b <= deg_mem[img_ra_b];
    end
  end

  // registered image map, two read ports
  always_ff @(posedge clk) begin
    if (reg_we) begin
      reg_mem[reg_waddr] <= reg_wdata;
    end
    if (img_re) begin
      reg_a <= reg_mem[img_ra_a];
      reg_b <= reg_mem[img_ra_b];
    end
  end

  // weights
  always_ff @(posedge clk) begin
    if (rst) begin
      w_inl <= 16'sd256;
      w_con <= 16'sd26;
      w_stb <= 16'sd256;
    end else if (cfg_we) begin
      case (cfg_index)
        ipss_pkg::CFG_W_INLIERS: w_inl <= signed'(cfg_data);
        ipss_pkg::CFG_W_CONNECT: w_con <= signed'(cfg_data);
        ipss_pkg::CFG_W_STABLE:  w_stb <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
      sweep_addr <= '0;
      sweep_deg <= 1'b1;
      sweep_reg <= 1'b1;
      sweep_op <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ipss_pkg::ST_SWEEP) begin
        sweep_addr <= sweep_addr + IMG_AW'(1);
      end
      if (s_acc) begin
        sweep_addr <= '0;
        sweep_op <= 1'b1;
        sweep_deg <= (s_tuser == ipss_pkg::OP_CLEAR_PAIRS);
        sweep_reg <= (s_tuser == ipss_pkg::OP_CLEAR_REG);
        if (s_tuser == ipss_pkg::OP_CLEAR_PAIRS) begin
          pair_count <= '0;
        end else if (s_tuser == ipss_pkg::OP_ADD_PAIR && !full_tbl) begin
          pair_count <= pair_count + (PAIR_AW+1)'(1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request and result datapath
  always_ff @(posedge clk) begin
    if (s_acc) begin
      req_op <= s_tuser;
      req_rec <= in_rec;
      req_q <= s_tdata[58:49];
      idx <= '0;
      found <= 1'b0;
      res_code <= ipss_pkg::RC_OK;
      res_bf <= '0;
      res_bs <= '0;
      res_bi <= '0;
      res_sc <= '0;
      if (s_tuser == ipss_pkg::OP_ADD_PAIR) begin
        if (full_tbl) begin
          res_code <= ipss_pkg::RC_FULL;
        end else begin
          res_bi <= pair_count[PAIR_AW-1:0];
        end
      end else if (s_tuser == ipss_pkg::OP_QUERY) begin
        if ({1'b0, s_tdata[58:49]} >= pair_count) begin
          res_code <= ipss_pkg::RC_RANGE;
        end else begin
          res_bi <= s_tdata[58:49];
        end
      end
    end
    // second bump sees the first when both images match
    if (state == ipss_pkg::ST_ADD_WA) begin
      if (req_rec.im1 == req_rec.im2) begin
        nb <= (na == ipss_pkg::DEG_MAX) ? na : na + 12'd1;
      end else begin
        nb <= (deg_b == ipss_pkg::DEG_MAX) ? deg_b : deg_b + 12'd1;
      end
    end
    if (state == ipss_pkg::ST_C_RD && idx == pair_count && !found) begin
      res_code <= ipss_pkg::RC_NONE;
    end
    if (state == ipss_pkg::ST_IMG_CHK && skip) begin
      idx <= idx + (PAIR_AW+1)'(1);
    end
    if (state == ipss_pkg::ST_SCORE && sc_done) begin
      if (req_op == ipss_pkg::OP_CHOOSE) begin
        idx <= idx + (PAIR_AW+1)'(1);
        // strict compare keeps the lower index on ties
        if (!found || sc_val > best) begin
          found <= 1'b1;
          best <= sc_val;
          res_bf <= pair_rd.im1;
          res_bs <= pair_rd.im2;
          res_bi <= idx[PAIR_AW-1:0];
          res_sc <= sc_val;
        end
      end else begin
        res_sc <= sc_val;
        res_bi <= req_q;
      end
    end
    if (out_load) begin
      m_tuser <= res_code;
      m_tdata <= {6'd0, res_sc, res_bi, res_bs, res_bf};
    end
  end

  ipss_score u_score (
    .clk   (clk),
    .rst   (rst),
    .start (sc_start),
    .rec   (pair_rd),
    .dsum  (dsum),
    .w_inl (w_inl),
    .w_con (w_con),
    .w_stb (w_stb),
    .done  (sc_done),
    .score (sc_val)
  );

endmodule

FILE: hdl/ipss_score.sv
// iterative pair score unit: log of inlier count, weighting and saturation
module ipss_score (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ipss_pkg::pair_rec_t   rec,
  input  logic [12:0]           dsum,
  input  logic signed [15:0]    w_inl,
  input  logic signed [15:0]    w_con,
  input  logic signed [15:0]    w_stb,
  output logic                  done,
  output logic signed [31:0]    score
);

  ipss_pkg::sc_state_t state, state_next;

  logic [31:0] m;
  logic [4:0]  n;
  logic [29:0] frac;
  logic [4:0]  cnt;
  logic [45:0] plo;
  logic [44:0] phi;
  logic [16:0] ln_val;
  logic signed [33:0] ti_raw;
  logic signed [29:0] tc_raw;

  logic [20:0] v;
  logic [63:0] sq;
  logic [32:0] sq_t;
  logic [63:0] full;
  logic signed [34:0] ti_rnd;
  logic signed [34:0] ti_sh;
  logic signed [37:0] tot;

  // start value, squaring step, log rounding and weighted sum
  always_comb begin
    v = (rec.inl <= 21'sd0) ? 21'd1 : 21'(rec.inl + 21'sd1);
    sq = {32'd0, m} * {32'd0, m};
    sq_t = sq[63:31];
    full = {1'b0, phi, 18'd0} + {18'd0, plo} + (64'd1 << (ipss_pkg::LN_SHIFT - 1));
    ti_rnd = 35'(ti_raw) + (35'sd1 <<< (ipss_pkg::TI_SHIFT - 1));
    ti_sh = ti_rnd >>> ipss_pkg::TI_SHIFT;
    tot = 38'(ti_sh) + 38'(signed'({tc_raw, 4'd0}));
    if (rec.tv && rec.st) begin
      tot = tot + 38'(signed'({w_stb, 4'd0}));
    end
    if (rec.dg) begin
      tot = tot - 38'(ipss_pkg::PENALTY);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipss_pkg::SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ipss_pkg::SC_IDLE: if (start) state_next = ipss_pkg::SC_NORM;
      ipss_pkg::SC_NORM: if (m[31]) state_next = ipss_pkg::SC_SQ;
      ipss_pkg::SC_SQ:   if (cnt == 5'd29) state_next = ipss_pkg::SC_PLO;
      ipss_pkg::SC_PLO:  state_next = ipss_pkg::SC_PHI;
      ipss_pkg::SC_PHI:  state_next = ipss_pkg::SC_LN;
      ipss_pkg::SC_LN:   state_next = ipss_pkg::SC_MUL;
      ipss_pkg::SC_MUL:  state_next = ipss_pkg::SC_SUM;
      ipss_pkg::SC_SUM:  state_next = ipss_pkg::SC_IDLE;
      default:           state_next = ipss_pkg::SC_IDLE;
    endcase
  end

  // done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ipss_pkg::SC_SUM);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ipss_pkg::SC_IDLE: begin
        m <= {v, 11'd0};
        n <= 5'd20;
        cnt <= 5'd0;
        frac <= 30'd0;
      end
      ipss_pkg::SC_NORM: begin
        if (!m[31]) begin
          m <= {m[30:0], 1'b0};
          n <= n - 5'd1;
        end
      end
      ipss_pkg::SC_SQ: begin
        // one fraction bit of log2 per squaring
        if (sq_t[32]) begin
          m <= sq_t[32:1];
        end else begin
          m <= sq_t[31:0];
        end
        frac <= {frac[28:0], sq_t[32]};
        cnt <= cnt + 5'd1;
      end
      ipss_pkg::SC_PLO: plo <= {28'd0, frac[17:0]} * {18'd0, ipss_pkg::LN2_Q28};
      ipss_pkg::SC_PHI: phi <= 45'({n, frac[29:18]}) * 45'(ipss_pkg::LN2_Q28);
      ipss_pkg::SC_LN:  ln_val <= full[ipss_pkg::LN_SHIFT+16:ipss_pkg::LN_SHIFT];
      ipss_pkg::SC_MUL: begin
        ti_raw <= 34'(w_inl) * 34'(signed'({1'b0, ln_val}));
        tc_raw <= 30'(w_con) * 30'(signed'({1'b0, dsum}));
      end
      ipss_pkg::SC_SUM: begin
        // saturate to 32 bits
        if (tot > 38'sd2147483647) begin
          score <= 32'sh7FFFFFFF;
        end else if (tot < -38'sd2147483648) begin
          score <= 32'sh80000000;
        end else begin
          score <= tot[31:0];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: tb/tb_image_pair_score_select.sv
// testbench for image_pair_score_select: directed and random requests, scoreboard check
module tb_image_pair_score_select;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 300000;

  typedef struct {
    logic [2:0]         op;
    logic [11:0]        lead_image;
    logic [11:0]        second_image;
    logic signed [20:0] inlier_count;
    logic               fund_ok;
    logic               twoview_good;
    logic               is_stable;
    logic               degenerate;
    logic [9:0]         query_index;
  } request_t;

  typedef struct {
    logic [1:0]         code;
    logic [11:0]        best_first;
    logic [11:0]        best_second;
    logic [9:0]         best_index;
    logic signed [31:0] score;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  image_pair_score_select DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow copy of the pair table, degrees, registrations and weights
  request_t    pairs [ipss_pkg::MAX_PAIRS];
  int          pair_total = 0;
  int          degree [ipss_pkg::MAX_IMAGES];
  bit          registered [ipss_pkg::MAX_IMAGES];
  longint      w_inl = 256, w_con = 26, w_stb = 256;

  request_t    pending [$];
  answer_t     expected_answers [$];
  request_t    on_bus;
  int          tx_gap = 0, rx_gap = 0, rx_hold = 0;
  int          hold_asks = 0, hold_done = 0;
  bit          calm = 1'b0;
  int          mismatches = 0, requests_sent = 0, answers_seen = 0, chooses = 0;
  int          queued = 0;
  int          idle_cycles = 0;
  int          pool [16];

  // natural log of 1+max(0,inliers), rounded to LOG_FRAC_BITS
  function automatic longint unsigned ln_of_inliers(logic signed [20:0] inl);
    longint unsigned v, m, lg, prod;
    int n;
    v = 64'd1;
    if (inl > 0) v = 64'(unsigned'(inl)) + 64'd1;
    n = 0;
    while ((v >> (n + 1)) != 0) n++;
    m = (v << 31) >> n;
    lg = 64'(n) << 30;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        lg = lg | (64'd1 << (29 - i));
      end
    end
    prod = lg * 64'd186065280;
    return (prod + (64'd1 << (57 - ipss_pkg::LOG_FRAC_BITS))) >>
           (58 - ipss_pkg::LOG_FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] pair_score(int idx);
    longint s;
    s = (w_inl * longint'(ln_of_inliers(pairs[idx].inlier_count))
         + (64'sd1 << (ipss_pkg::LOG_FRAC_BITS - 5))) >>> (ipss_pkg::LOG_FRAC_BITS - 4);
    s += w_con * longint'(degree[pairs[idx].lead_image] + degree[pairs[idx].second_image])
         * 16;
    if (pairs[idx].twoview_good && pairs[idx].is_stable) s += w_stb * 16;
    if (pairs[idx].degenerate) s -= ipss_pkg::PENALTY;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // apply one accepted request to the shadow state and queue its answer
  function automatic void predict_answer(request_t r);
    answer_t a;
    bit found;
    logic signed [31:0] sc;
    a = '{ipss_pkg::RC_OK, 12'd0, 12'd0, 10'd0, 32'sd0};
    found = 1'b0;
    case (r.op)
      ipss_pkg::OP_CLEAR_PAIRS: begin
        pair_total = 0;
        foreach (degree[i]) degree[i] = 0;
      end
      ipss_pkg::OP_ADD_PAIR: begin
        if (pair_total >= ipss_pkg::MAX_PAIRS) begin
          a.code = ipss_pkg::RC_FULL;
        end else begin
          pairs[pair_total] = r;
          if (degree[r.lead_image] < 4095) degree[r.lead_image]++;
          if (degree[r.second_image] < 4095) degree[r.second_image]++;
          a.best_index = pair_total[9:0];
          pair_total++;
        end
      end
      ipss_pkg::OP_REG_IMAGE: registered[r.lead_image] = 1'b1;
      ipss_pkg::OP_CLEAR_REG: foreach (registered[i]) registered[i] = 1'b0;
      ipss_pkg::OP_QUERY: begin
        if (int'(r.query_index) >= pair_total) begin
          a.code = ipss_pkg::RC_RANGE;
        end else begin
          a.best_index = r.query_index;
          a.score = pair_score(int'(r.query_index));
        end
      end
      ipss_pkg::OP_CHOOSE: begin
        for (int i = 0; i < pair_total; i++) begin
          if (!pairs[i].fund_ok || pairs[i].degenerate) continue;
          if (registered[pairs[i].lead_image] || registered[pairs[i].second_image]) continue;
          sc = pair_score(i);
          if (!found || sc > a.score) begin
            found = 1'b1;
            a.score = sc;
            a.best_index = i[9:0];
            a.best_first = pairs[i].lead_image;
            a.best_second = pairs[i].second_image;
          end
        end
        if (!found) a.code = ipss_pkg::RC_NONE;
      end
      default: ;
    endcase
    expected_answers.insert(expected_answers.size(), a);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_answer(on_bus);
        requests_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          on_bus = pending.pop_front();
          // lead_image, second_image, inlier_count, fund_ok, twoview_good,
          // is_stable, degenerate, query_index from the lowest bit up
          s_tdata <= {5'd0, on_bus.query_index, on_bus.degenerate, on_bus.is_stable,
                      on_bus.twoview_good, on_bus.fund_ok, on_bus.inlier_count,
                      on_bus.second_image, on_bus.lead_image};
          s_tuser <= on_bus.op;
          s_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 6);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and scoreboard
  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        answers_seen++;
        got = '{m_tuser, m_tdata[11:0], m_tdata[23:12], m_tdata[33:24], m_tdata[65:34]};
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result code=%0d", got.code);
        end else begin
          want = expected_answers.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected code=%0d first=%0d second=%0d idx=%0d score=%0d, %s",
                       want.code, want.best_first, want.best_second, want.best_index,
                       want.score, $sformatf("got code=%0d first=%0d second=%0d idx=%0d score=%0d",
                       got.code, got.best_first, got.best_second, got.best_index, got.score));
          end
        end
      end
      // long hold-off, random stall bursts, or ready
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        rx_hold = 400;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 6);
      end
    end
  end

  // watchdog on cycles without any request or result moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic request_t random_request(logic [2:0] op);
    request_t r;
    r.op = op;
    r.lead_image = 12'($urandom);
    r.second_image = 12'($urandom);
    r.inlier_count = 21'($urandom);
    r.fund_ok = 1'($urandom);
    r.twoview_good = 1'($urandom);
    r.is_stable = 1'($urandom);
    r.degenerate = 1'($urandom);
    r.query_index = 10'($urandom);
    return r;
  endfunction

  task automatic queue_request(request_t r);
    if (r.op == ipss_pkg::OP_CHOOSE) chooses++;
    queued++;
    pending.insert(pending.size(), r);
  endtask

  // add a pair with images from the small pool and mostly modest inlier counts
  task automatic queue_pool_add(bit likely_ok);
    request_t r;
    r = random_request(ipss_pkg::OP_ADD_PAIR);
    r.lead_image = 12'(pool[$urandom_range(0, 15)]);
    r.second_image = 12'(pool[$urandom_range(0, 15)]);
    if ($urandom_range(0, 3) != 0) r.inlier_count = 21'($urandom_range(0, 3000));
    if (likely_ok && $urandom_range(0, 3) != 0) begin
      r.fund_ok = 1'b1;
      r.degenerate = 1'b0;
    end
    queue_request(r);
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || s_tvalid || expected_answers.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_weight(logic [1:0] idx, logic signed [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == ipss_pkg::CFG_W_INLIERS) w_inl = val;
    else if (idx == ipss_pkg::CFG_W_CONNECT) w_con = val;
    else w_stb = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_weight();
    case ($urandom_range(0, 4))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  // stimulus
  initial begin
    request_t r;
    foreach (degree[i]) degree[i] = 0;
    foreach (registered[i]) registered[i] = 1'b0;
    foreach (pool[i]) pool[i] = $urandom_range(0, 4095);
    pool[0] = 0;
    pool[1] = 4095;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: every op, empty table cases, field extremes
    queue_request(random_request(ipss_pkg::OP_CHOOSE));
    queue_request(random_request(ipss_pkg::OP_QUERY));
    r = random_request(ipss_pkg::OP_ADD_PAIR);
    r.lead_image = 12'd0; r.second_image = 12'd4095; r.inlier_count = -21'sd1;
    r.fund_ok = 1'b1; r.degenerate = 1'b0;
    queue_request(r);
    r.inlier_count = 21'sd1048575; r.lead_image = 12'd4095; r.second_image = 12'd4095;
    r.twoview_good = 1'b1; r.is_stable = 1'b1;
    queue_request(r);
    r.inlier_count = 21'h10_0000; r.degenerate = 1'b1;
    queue_request(r);
    r.inlier_count = 21'sd0; r.degenerate = 1'b0; r.fund_ok = 1'b0;
    queue_request(r);
    for (int q = 0; q < 5; q++) begin
      r = random_request(ipss_pkg::OP_QUERY);
      r.query_index = 10'(q);
      queue_request(r);
    end
    r.query_index = 10'd1023;
    queue_request(r);
    queue_request(random_request(ipss_pkg::OP_CHOOSE));
    r = random_request(ipss_pkg::OP_REG_IMAGE); r.lead_image = 12'd4095;
    queue_request(r);
    queue_request(random_request(ipss_pkg::OP_CHOOSE));
    r.lead_image = 12'd0;
    queue_request(r);
    queue_request(random_request(ipss_pkg::OP_CHOOSE));
    queue_request(random_request(ipss_pkg::OP_CLEAR_REG));
    queue_request(random_request(ipss_pkg::OP_CHOOSE));
    queue_request(random_request(3'd6));
    queue_request(random_request(3'd7));
    queue_request(random_request(ipss_pkg::OP_CLEAR_PAIRS));
    queue_request(random_request(ipss_pkg::OP_QUERY));
    wait_idle();

    // heavy degrees on one image under extreme weights
    write_weight(ipss_pkg::CFG_W_INLIERS, 16'sh7FFF);
    write_weight(ipss_pkg::CFG_W_CONNECT, 16'sh7FFF);
    write_weight(ipss_pkg::CFG_W_STABLE, 16'sh7FFF);
    for (int k = 0; k < 64; k++) begin
      r = random_request(ipss_pkg::OP_ADD_PAIR);
      r.lead_image = 12'd7; r.second_image = 12'd7;
      r.fund_ok = ($urandom_range(0, 15) == 0);
      queue_request(r);
    end
    r = random_request(ipss_pkg::OP_QUERY); r.query_index = 10'd63;
    queue_request(r);
    queue_request(random_request(ipss_pkg::OP_CHOOSE));
    wait_idle();
    write_weight(ipss_pkg::CFG_W_CONNECT, 16'sh8000);
    write_weight(ipss_pkg::CFG_W_INLIERS, 16'sh8000);
    write_weight(ipss_pkg::CFG_W_STABLE, 16'sh8000);
    r = random_request(ipss_pkg::OP_QUERY); r.query_index = 10'd63;
    queue_request(r);
    r.query_index = 10'd0;
    queue_request(r);
    queue_request(random_request(ipss_pkg::OP_CLEAR_PAIRS));
    wait_idle();

    // random phases: fill a small table, register, query, choose
    for (int phase = 0; queued < 740; phase++) begin
      if (phase % 3 == 1) begin
        wait_idle();
        write_weight(ipss_pkg::CFG_W_INLIERS, pick_weight());
        write_weight(ipss_pkg::CFG_W_CONNECT, pick_weight());
        write_weight(ipss_pkg::CFG_W_STABLE, pick_weight());
      end
      if (phase == 4) hold_asks++;
      if (queued > 600) calm = 1'b1;
      queue_request(random_request(ipss_pkg::OP_CLEAR_PAIRS));
      if ($urandom_range(0, 2) == 0) begin
        queue_request(random_request(ipss_pkg::OP_CLEAR_REG));
      end
      for (int k = $urandom_range(1, 24); k > 0; k--) begin
        queue_pool_add(1'b1);
      end
      for (int k = 0; k < 12; k++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            r = random_request(ipss_pkg::OP_REG_IMAGE);
            r.lead_image = 12'(pool[$urandom_range(0, 15)]);
            queue_request(r);
          end
          2, 3: begin
            r = random_request(ipss_pkg::OP_QUERY);
            if ($urandom_range(0, 3) != 0) r.query_index = 10'($urandom_range(0, 30));
            queue_request(r);
          end
          4, 5, 6: queue_request(random_request(ipss_pkg::OP_CHOOSE));
          7: queue_pool_add(1'b0);
          8: queue_request(random_request(3'($urandom_range(6, 7))));
          default: queue_request(random_request(ipss_pkg::OP_CLEAR_REG));
        endcase
      end
    end

    // wait for every result, then let the pipe settle
    while (pending.size() > 0 || s_tvalid || expected_answers.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d requests with %0d results, %0d choose requests, heavy degrees",
             requests_sent, answers_seen, chooses);
    $display("under extreme weights and random weight sets; %0d mismatches", mismatches);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: image_pair_score_select.f
hdl/ipss_pkg.sv
hdl/ipss_score.sv
hdl/image_pair_score_select.sv
tb/tb_image_pair_score_select.sv
